// ===== hdl/pfsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsd_pkg: shared types and constants of the page free space directory
// Command and status codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfsd_pkg;

    localparam int MAX_PAGES_DEF = 256;
    localparam int PAGE_W        = 8;
    localparam int COUNT_W       = 16;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND_INSERT   = 2'd0,
        CMD_INC           = 2'd1,
        CMD_DEC           = 2'd2,
        CMD_FIND_NONEMPTY = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_NONE      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_ADDR = 2'd1,
        S_EVAL = 2'd2,
        S_OUT  = 2'd3
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_item;
        logic rd_issue;
        logic ptr_inc;
        logic fin_miss;
        logic fin_eval;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic in_range;
        logic eval_stop;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== hdl/pfsd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsd_ctrl: sequencing state machine
// Accepts one item, walks the scan through address and evaluate steps and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module pfsd_ctrl
    import pfsd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_ADDR;
                end
            end
            S_ADDR: begin
                if (sts.in_range) begin
                    cmd.rd_issue = 1'b1;
                    state_next   = S_EVAL;
                end else begin
                    cmd.fin_miss = 1'b1;
                    state_next   = S_OUT;
                end
            end
            S_EVAL: begin
                if (sts.eval_stop) begin
                    cmd.fin_eval = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_ADDR;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/pfsd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsd_datapath: count memory, scan pointer and result registers
// Holds the page counts, the pages-in-use count and the capacity register,
// forms each result and drives the output register.
// ----------------------------------------------------------------------------
module pfsd_datapath
    import pfsd_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [PAGE_W-1:0]   s_page_index,
    input  ctrl_cmd_t           cmd,
    output ctrl_sts_t           sts,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [PAGE_W-1:0]   m_result_page,
    output logic                m_found,
    output logic                m_appended,
    output logic [COUNT_W-1:0]  m_count_after,
    output logic [STATUS_W-1:0] m_status
);

    localparam int AW = $clog2(MAX_PAGES);
    localparam int CW = $clog2(MAX_PAGES + 1);
    localparam int SW = (CW > PAGE_W) ? CW : PAGE_W;

    logic [COUNT_W-1:0] mem [MAX_PAGES];

    logic [COUNT_W-1:0] cap_reg;
    logic [CW-1:0]      pages_reg;
    logic [SW-1:0]      ptr_reg;
    cmd_t               cmd_reg;
    logic [COUNT_W-1:0] rd_data_reg;

    logic [PAGE_W-1:0]  res_page_reg;
    logic               res_found_reg;
    logic               res_app_reg;
    logic [COUNT_W-1:0] res_count_reg;
    status_t            res_status_reg;

    logic               m_valid_reg;
    logic [PAGE_W-1:0]  out_page_reg;
    logic               out_found_reg;
    logic               out_app_reg;
    logic [COUNT_W-1:0] out_count_reg;
    status_t            out_status_reg;

    logic [SW-1:0]      pages_ext;
    logic               has_room;
    logic               below_cap;
    logic               rd_zero;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [COUNT_W-1:0] wr_data;

    assign pages_ext = SW'(pages_reg);
    assign has_room  = (pages_reg < CW'(MAX_PAGES));
    assign below_cap = (rd_data_reg < cap_reg);
    assign rd_zero   = (rd_data_reg == '0);

    assign sts.in_range  = (ptr_reg < pages_ext);
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.eval_stop = (cmd_reg == CMD_INC) || (cmd_reg == CMD_DEC) ||
                           ((cmd_reg == CMD_FIND_INSERT) && below_cap) ||
                           ((cmd_reg == CMD_FIND_NONEMPTY) && !rd_zero);

    // One write port: the append clears the new page, updates store the new count.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = ptr_reg[AW-1:0];
        wr_data = '0;
        if (cmd.fin_miss && (cmd_reg == CMD_FIND_INSERT) && has_room) begin
            wr_en   = 1'b1;
            wr_addr = pages_reg[AW-1:0];
        end else if (cmd.fin_eval && (cmd_reg == CMD_INC) && below_cap) begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg + COUNT_W'(1);
        end else if (cmd.fin_eval && (cmd_reg == CMD_DEC) && !rd_zero) begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= COUNT_W'(1);
            pages_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.fin_miss && (cmd_reg == CMD_FIND_INSERT) && has_room) begin
                pages_reg <= pages_reg + CW'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            cmd_reg <= cmd_t'(s_command);
            ptr_reg <= (cmd_t'(s_command) == CMD_FIND_INSERT) ? '0 : SW'(s_page_index);
        end else if (cmd.ptr_inc) begin
            ptr_reg <= ptr_reg + SW'(1);
        end

        if (cmd.fin_miss) begin
            case (cmd_reg)
                CMD_FIND_INSERT: begin
                    res_count_reg <= '0;
                    if (has_room) begin
                        res_page_reg   <= pages_ext[PAGE_W-1:0];
                        res_found_reg  <= 1'b1;
                        res_app_reg    <= 1'b1;
                        res_status_reg <= ST_OK;
                    end else begin
                        res_page_reg   <= '0;
                        res_found_reg  <= 1'b0;
                        res_app_reg    <= 1'b0;
                        res_status_reg <= ST_FULL;
                    end
                end
                CMD_FIND_NONEMPTY: begin
                    res_page_reg   <= '0;
                    res_found_reg  <= 1'b0;
                    res_app_reg    <= 1'b0;
                    res_count_reg  <= '0;
                    res_status_reg <= ST_NONE;
                end
                default: begin
                    res_page_reg   <= ptr_reg[PAGE_W-1:0];
                    res_found_reg  <= 1'b0;
                    res_app_reg    <= 1'b0;
                    res_count_reg  <= '0;
                    res_status_reg <= ST_NOT_ALLOC;
                end
            endcase
        end else if (cmd.fin_eval) begin
            res_page_reg  <= ptr_reg[PAGE_W-1:0];
            res_found_reg <= 1'b1;
            res_app_reg   <= 1'b0;
            case (cmd_reg)
                CMD_INC: begin
                    if (below_cap) begin
                        res_count_reg  <= rd_data_reg + COUNT_W'(1);
                        res_status_reg <= ST_OK;
                    end else begin
                        res_count_reg  <= rd_data_reg;
                        res_status_reg <= ST_OVERFLOW;
                    end
                end
                CMD_DEC: begin
                    if (rd_zero) begin
                        res_count_reg  <= '0;
                        res_status_reg <= ST_UNDERFLOW;
                    end else begin
                        res_count_reg  <= rd_data_reg - COUNT_W'(1);
                        res_status_reg <= ST_OK;
                    end
                end
                default: begin
                    res_count_reg  <= rd_data_reg;
                    res_status_reg <= ST_OK;
                end
            endcase
        end

        if (cmd.out_load) begin
            out_page_reg   <= res_page_reg;
            out_found_reg  <= res_found_reg;
            out_app_reg    <= res_app_reg;
            out_count_reg  <= res_count_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_page = out_page_reg;
    assign m_found       = out_found_reg;
    assign m_appended    = out_app_reg;
    assign m_count_after = out_count_reg;
    assign m_status      = out_status_reg;

    // The directory never grows past its size.
    a_pages_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pages_reg <= CW'(MAX_PAGES))
        else $error("pages in use exceeds table size");

    // An appended page is a found page with an empty count.
    a_append_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_app_reg |->
            out_found_reg && (out_status_reg == ST_OK) && (out_count_reg == '0))
        else $error("malformed append result");

    // A result that found nothing carries a zero count and an error status.
    a_miss_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !out_found_reg |->
            (out_count_reg == '0) && (out_status_reg != ST_OK))
        else $error("malformed miss result");

    // An append is reflected in the count of pages in use in the next cycle.
    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_miss && (cmd_reg == CMD_FIND_INSERT) && has_room |=>
            pages_reg == $past(pages_reg) + CW'(1))
        else $error("append did not grow the directory");

endmodule

// ===== hdl/page_free_space_directory_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_free_space_directory_unit: first-fit free space map for a page heap
// Keeps a record count per allocated page, finds pages with a free slot or
// with records, and increments or decrements single page counts.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    s_command, s_page_index
//  m_        out        m_valid / m_ready    m_result_page, m_found, m_appended,
//                                            m_count_after, m_status
//  cfg_      in         cfg_wr_en            cfg_wr_data (page capacity)
//
// For an item the controller takes an address step and an evaluate step for
// each count memory entry it reads, around the registered memory read port:
// one entry for an increment or decrement of an allocated page, up to the
// pages in use for a search. A scan that runs past the last page in use ends
// in an address step that finds no entry in range; the output load follows.
// The block accepts one item at a time; the next item is taken while the
// previous result still waits in the output register.
// Reset clears the pages-in-use count and sets the capacity to one; the
// count memory is not cleared, since only entries written by an append are
// ever read. A stalled output holds the controller in its output state.
//
module page_free_space_directory_unit
    import pfsd_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Capacity register write.
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    // Command items.
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_command,
    input  logic [PAGE_W-1:0]   s_page_index,
    // Result items.
    output logic                m_valid,
    input  logic                m_ready,
    output logic [PAGE_W-1:0]   m_result_page,
    output logic                m_found,
    output logic                m_appended,
    output logic [COUNT_W-1:0]  m_count_after,
    output logic [STATUS_W-1:0] m_status
);

    // The controller only sequences; every data decision lives in the datapath.
    ctrl_cmd_t ctrl_cmd;
    ctrl_sts_t ctrl_sts;

    pfsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (ctrl_sts),
        .cmd     (ctrl_cmd)
    );

    pfsd_datapath #(
        .MAX_PAGES (MAX_PAGES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_command     (s_command),
        .s_page_index  (s_page_index),
        .cmd           (ctrl_cmd),
        .sts           (ctrl_sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_page (m_result_page),
        .m_found       (m_found),
        .m_appended    (m_appended),
        .m_count_after (m_count_after),
        .m_status      (m_status)
    );

endmodule

// ===== bench/page_free_space_directory_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_free_space_directory_unit_tb: self-checking bench for the directory
// Drives command items through the valid/ready input channel, predicts every
// result with a shadow copy of the page counts, the pages-in-use count and
// the capacity register, and compares each result field by field. Directed
// items cover the saturation and not-found cases; random items with bursty
// input and a stalling output then grow the table, fill it and exercise it.
// ----------------------------------------------------------------------------
module page_free_space_directory_unit_tb;
    import pfsd_pkg::*;

    localparam int NUM_PAGES    = MAX_PAGES_DEF;
    localparam int IDLE_LIMIT   = 5000;  // cycles with no handshake before giving up
    localparam int HOLD_CYCLES  = 400;   // long output hold-off for back-pressure
    localparam int DRAIN_CYCLES = 8;     // settle time before a capacity write
    localparam int CHUNK_ITEMS  = 75;

    typedef struct {
        logic [PAGE_W-1:0]  page;
        logic               found;
        logic               appended;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } dir_result_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [COUNT_W-1:0]  cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command;
    logic [PAGE_W-1:0]   s_page_index;
    logic                m_valid;
    logic                m_ready;
    logic [PAGE_W-1:0]   m_result_page;
    logic                m_found;
    logic                m_appended;
    logic [COUNT_W-1:0]  m_count_after;
    logic [STATUS_W-1:0] m_status;

    // Shadow of the directory state, updated as each item is accepted.
    logic [COUNT_W-1:0] page_count_shadow [NUM_PAGES];
    int unsigned        pages_used_shadow;
    logic [COUNT_W-1:0] capacity_shadow;

    dir_result_t pending_results [$];

    int unsigned errors        = 0;
    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned appends_seen  = 0;
    int unsigned status_seen [6];
    int unsigned burst_left    = 0;
    int unsigned stall_pct     = 0;
    bit          hold_req      = 1'b0;

    always #5 aclk = ~aclk;

    page_free_space_directory_unit #(
        .MAX_PAGES (NUM_PAGES)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_page_index  (s_page_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_page (m_result_page),
        .m_found       (m_found),
        .m_appended    (m_appended),
        .m_count_after (m_count_after),
        .m_status      (m_status)
    );

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Applies one command to the shadow state and returns the result the
    // block must produce for it.
    function automatic dir_result_t next_directory_result(cmd_t cmd,
                                                          logic [PAGE_W-1:0] idx);
        dir_result_t r;
        bit          hit;
        r.page     = '0;
        r.found    = 1'b0;
        r.appended = 1'b0;
        r.count    = '0;
        r.status   = ST_OK;
        hit        = 1'b0;
        case (cmd)
            CMD_FIND_INSERT: begin
                // First fit over the allocated pages, then append or report full.
                for (int i = 0; i < int'(pages_used_shadow); i++) begin
                    if (!hit && page_count_shadow[i] < capacity_shadow) begin
                        hit     = 1'b1;
                        r.page  = PAGE_W'(i);
                        r.found = 1'b1;
                        r.count = page_count_shadow[i];
                    end
                end
                if (!hit) begin
                    if (pages_used_shadow < NUM_PAGES) begin
                        page_count_shadow[pages_used_shadow] = '0;
                        r.page     = PAGE_W'(pages_used_shadow);
                        r.found    = 1'b1;
                        r.appended = 1'b1;
                        pages_used_shadow++;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
            end
            CMD_FIND_NONEMPTY: begin
                for (int i = int'(idx); i < int'(pages_used_shadow); i++) begin
                    if (!hit && page_count_shadow[i] != 0) begin
                        hit     = 1'b1;
                        r.page  = PAGE_W'(i);
                        r.found = 1'b1;
                        r.count = page_count_shadow[i];
                    end
                end
                if (!hit)
                    r.status = ST_NONE;
            end
            default: begin
                r.page = idx;
                if (idx >= pages_used_shadow) begin
                    r.status = ST_NOT_ALLOC;
                end else begin
                    r.found = 1'b1;
                    if (cmd == CMD_INC) begin
                        // A count above a lowered capacity is left alone.
                        if (page_count_shadow[idx] >= capacity_shadow)
                            r.status = ST_OVERFLOW;
                        else
                            page_count_shadow[idx] = page_count_shadow[idx] + 1'b1;
                    end else begin
                        if (page_count_shadow[idx] == 0)
                            r.status = ST_UNDERFLOW;
                        else
                            page_count_shadow[idx] = page_count_shadow[idx] - 1'b1;
                    end
                    r.count = page_count_shadow[idx];
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one item and returns at the edge where it is accepted. Items go
    // out in bursts of random length; valid drops only between bursts.
    task automatic send_item(cmd_t cmd, logic [PAGE_W-1:0] idx);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_page_index <= idx;
        do
            @(posedge aclk);
        while (!s_ready);
        pending_results.push_back(next_directory_result(cmd, idx));
        items_sent++;
        burst_left--;
    endtask

    // Stops offering and waits until every predicted result has been taken,
    // then lets the block settle.
    task automatic wait_for_idle();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_capacity(logic [COUNT_W-1:0] value);
        wait_for_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        capacity_shadow = value;
        cfg_wr_en       <= 1'b0;
    endtask

    // Mostly addresses allocated pages, with some just past the end of the
    // table and some anywhere.
    function automatic logic [PAGE_W-1:0] pick_index();
        int unsigned r;
        int unsigned near;
        r = $urandom_range(0, 99);
        if (r < 80 && pages_used_shadow > 0)
            return PAGE_W'($urandom_range(0, pages_used_shadow - 1));
        if (r < 90) begin
            near = pages_used_shadow + $urandom_range(0, 2);
            return (near > NUM_PAGES - 1) ? PAGE_W'(NUM_PAGES - 1) : PAGE_W'(near);
        end
        return PAGE_W'($urandom_range(0, NUM_PAGES - 1));
    endfunction

    function automatic cmd_t pick_command();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return CMD_FIND_INSERT;
        if (r < 60)
            return CMD_INC;
        if (r < 80)
            return CMD_DEC;
        return CMD_FIND_NONEMPTY;
    endfunction

    task automatic run_random_items(int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            send_item(pick_command(), pick_index());
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // The receiver stalls at a per-phase rate, or holds off for a long
    // stretch when asked.
    initial begin : receiver
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        dir_result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got page %0d status %0d",
                         $time, m_result_page, m_status);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_page", want.page, m_result_page);
                check_field("found", want.found, m_found);
                check_field("appended", want.appended, m_appended);
                check_field("count_after", want.count, m_count_after);
                check_field("status", want.status, m_status);
                status_seen[int'(want.status)]++;
                if (want.appended)
                    appends_seen++;
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("page_free_space_directory_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Updates and searches on an empty table.
    task automatic test_empty_table();
        send_item(CMD_INC, 8'd0);
        send_item(CMD_DEC, 8'hFF);
        send_item(CMD_FIND_NONEMPTY, 8'd0);
        send_item(CMD_FIND_NONEMPTY, 8'hFF);
    endtask

    // Appends, counts up to capacity, saturates at both ends, decrements and searches.
    task automatic test_update_and_saturate();
        set_capacity(16'd2);
        send_item(CMD_FIND_INSERT, 8'd0);
        send_item(CMD_INC, 8'd0);
        send_item(CMD_INC, 8'd0);
        send_item(CMD_INC, 8'd0);           // overflow saturates
        send_item(CMD_DEC, 8'd1);           // page 1 not yet allocated
        send_item(CMD_FIND_INSERT, 8'hAA);  // page 0 is full, so append page 1
        send_item(CMD_DEC, 8'd1);           // underflow saturates
        send_item(CMD_FIND_NONEMPTY, 8'd0);
        send_item(CMD_FIND_NONEMPTY, 8'd1);
        send_item(CMD_DEC, 8'd0);
        send_item(CMD_FIND_INSERT, 8'h55);  // page 0 has a free slot again
        send_item(CMD_INC, 8'd1);
        send_item(CMD_INC, 8'd0);
    endtask

    // A count left above a lowered capacity, and capacity zero.
    task automatic test_capacity_changes();
        set_capacity(16'd1);
        send_item(CMD_INC, 8'd0);           // count 2 stays above capacity 1
        send_item(CMD_FIND_INSERT, 8'd0);   // both pages full, append page 2
        set_capacity(16'd0);
        send_item(CMD_FIND_INSERT, 8'd0);
        send_item(CMD_INC, 8'd3);           // every increment saturates
        set_capacity(16'hFFFF);
        send_item(CMD_FIND_INSERT, 8'd0);
        send_item(CMD_INC, 8'd2);
    endtask

    // Random traffic while the table is still growing.
    task automatic test_random_growing();
        logic [COUNT_W-1:0] caps [4] = '{16'd1, 16'd3, 16'hFFFF, 16'd2};
        foreach (caps[k]) begin
            set_capacity(caps[k]);
            stall_pct = $urandom_range(0, 3) * 25;
            run_random_items(CHUNK_ITEMS);
        end
    endtask

    // With capacity zero every insert appends, so the table fills up.
    task automatic test_table_full();
        set_capacity(16'd0);
        stall_pct = 20;
        while (pages_used_shadow < NUM_PAGES)
            send_item(CMD_FIND_INSERT, PAGE_W'($urandom_range(0, NUM_PAGES - 1)));
        send_item(CMD_FIND_INSERT, 8'd0);
        send_item(CMD_FIND_INSERT, 8'hFF);
    endtask

    // The receiver holds off while the sender keeps offering items.
    task automatic test_backpressure();
        set_capacity(16'd3);
        stall_pct  = 0;
        hold_req   = 1'b1;
        burst_left = 32;
        run_random_items(24);
    endtask

    // Random traffic over a full table.
    task automatic test_random_full_table();
        logic [COUNT_W-1:0] caps [4] = '{16'd4, 16'd1, 16'hFFFF, 16'd2};
        foreach (caps[k]) begin
            set_capacity(caps[k]);
            stall_pct = $urandom_range(0, 3) * 25;
            run_random_items(CHUNK_ITEMS);
        end
    endtask

    initial begin : main
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        s_valid      <= 1'b0;
        s_command    <= CMD_FIND_INSERT;
        s_page_index <= '0;
        pages_used_shadow = 0;
        capacity_shadow   = 16'd1;
        foreach (page_count_shadow[i])
            page_count_shadow[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_update_and_saturate();
        test_capacity_changes();
        test_random_growing();
        test_backpressure();
        test_table_full();
        test_random_full_table();

        wait_for_idle();
        repeat (20) @(posedge aclk);

        $display("Ran %0d items, checked %0d results: %0d appends, %0d table full,",
                 items_sent, results_seen, appends_seen, status_seen[int'(ST_FULL)]);
        $display("%0d unallocated, %0d overflow, %0d underflow, %0d none found.",
                 status_seen[int'(ST_NOT_ALLOC)], status_seen[int'(ST_OVERFLOW)],
                 status_seen[int'(ST_UNDERFLOW)], status_seen[int'(ST_NONE)]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("page_free_space_directory_unit: match");
        end else begin
            $display("page_free_space_directory_unit: mismatch");
        end
        $finish;
    end

endmodule
